@@ sv/assert_macros.svh @@
// Assertion macros used by the top level of the execute block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, masked while reset is held.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// Next-cycle implication, masked while reset is held.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/ase_pkg.sv @@
// Shared constants, operation codes and request types of the execute block.
package ase_pkg;

    // Default sizes
    localparam int DEF_PROGRAM_BYTES = 512;
    localparam int DEF_IO_BYTES      = 64;
    localparam int DEF_QUEUE_DEPTH   = 2;
    localparam int REG_COUNT         = 32;

    // Status register location in I/O space
    localparam logic [4:0] SREG_IO = 5'h1F;

    // Operation classes produced by decode
    localparam logic [3:0] OP_BAD  = 4'd0;
    localparam logic [3:0] OP_NOP  = 4'd1;
    localparam logic [3:0] OP_ADD  = 4'd2;
    localparam logic [3:0] OP_ADC  = 4'd3;
    localparam logic [3:0] OP_SUB  = 4'd4;
    localparam logic [3:0] OP_SBC  = 4'd5;
    localparam logic [3:0] OP_CP   = 4'd6;
    localparam logic [3:0] OP_MOV  = 4'd7;
    localparam logic [3:0] OP_SUBI = 4'd8;
    localparam logic [3:0] OP_SBCI = 4'd9;
    localparam logic [3:0] OP_CPI  = 4'd10;
    localparam logic [3:0] OP_LDI  = 4'd11;
    localparam logic [3:0] OP_INC  = 4'd12;
    localparam logic [3:0] OP_BSET = 4'd13;
    localparam logic [3:0] OP_SBI  = 4'd14;
    localparam logic [3:0] OP_RJMP = 4'd15;

    // Decoded request handed from front to back
    typedef struct packed {
        logic [3:0]  op;
        logic [4:0]  rd;    // destination / first operand register
        logic [4:0]  rr;    // second operand register
        logic [7:0]  kimm;  // 8-bit immediate
        logic [4:0]  ioa;   // I/O address for SBI
        logic [2:0]  bitn;  // bit number for SBI / flag set
        logic [11:0] k12;   // relative jump offset
    } t_dec;

    // Result of one request, program counter carried beside it
    typedef struct packed {
        logic       recognized;
        logic [7:0] status_byte;
        logic       dest_written;
        logic [6:0] dest_index;
        logic [7:0] dest_value;
    } t_res;

endpackage

@@ sv/avr_subset_execute.sv @@
// Top level of the 8-bit AVR subset execute block.
//
//   channel   | handshake          | payload
//   ----------+--------------------+----------------------------------------------
//   request   | push / full        | i_instruction
//   result    | empty / pop        | o_next_pc o_recognized o_status_byte
//             |                    | o_dest_written o_dest_index o_dest_value
//
// One instruction per cycle sustained while neither queue is full. A request is
// decoded into a QUEUE_DEPTH-entry queue (two by default); leaving the queue it
// reads the register file and I/O RAMs, then it executes in the execute stage
// and writes back, with the previous write forwarded. Reset clears valid bits at
// once, no clearing sweep. full rises when the decode queue holds QUEUE_DEPTH requests.
module avr_subset_execute #(
    parameter int PROGRAM_BYTES = ase_pkg::DEF_PROGRAM_BYTES,
    parameter int IO_BYTES      = ase_pkg::DEF_IO_BYTES,
    parameter int QUEUE_DEPTH   = ase_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [15:0]                      i_instruction,
    output logic                             empty,
    input  logic                             pop,
    output logic [$clog2(PROGRAM_BYTES)-1:0] o_next_pc,
    output logic                             o_recognized,
    output logic [7:0]                       o_status_byte,
    output logic                             o_dest_written,
    output logic [6:0]                       o_dest_index,
    output logic [7:0]                       o_dest_value
);

    `include "assert_macros.svh"

    localparam int PC_W  = $clog2(PROGRAM_BYTES);
    localparam int DEC_W = $bits(ase_pkg::t_dec);
    localparam int RES_W = PC_W + $bits(ase_pkg::t_res);

    ase_pkg::t_dec   dec_in, dec_head;
    logic            dec_empty, dec_pop;
    ase_pkg::t_res   res_in, res_head;
    logic [PC_W-1:0] res_pc_in;
    logic            res_full, res_push;

    // Classify the incoming word
    ase_front u_front (
        .i_word (i_instruction),
        .o_dec  (dec_in)
    );

    // Decouple decode from execute
    ase_fifo #(.WIDTH(DEC_W), .DEPTH(QUEUE_DEPTH)) u_dec_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (dec_in),
        .i_pop   (dec_pop),
        .o_data  (dec_head),
        .o_full  (full),
        .o_empty (dec_empty)
    );

    // Execute against architectural state
    ase_back #(.PROGRAM_BYTES(PROGRAM_BYTES), .IO_BYTES(IO_BYTES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dec_vld  (~dec_empty),
        .i_dec      (dec_head),
        .o_dec_pop  (dec_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in),
        .o_res_pc   (res_pc_in)
    );

    // Hold results until taken
    ase_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_pc_in, res_in}),
        .i_pop   (pop),
        .o_data  ({o_next_pc, res_head}),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_recognized   = res_head.recognized;
    assign o_status_byte  = res_head.status_byte;
    assign o_dest_written = res_head.dest_written;
    assign o_dest_index   = res_head.dest_index;
    assign o_dest_value   = res_head.dest_value;

    // Checks
    `ASSERT_IMP(a_res_room, i_clk, i_rst_n, res_push, !res_full)
    `ASSERT_IMP(a_pc_even, i_clk, i_rst_n, !empty, !o_next_pc[0])
    `ASSERT_IMP(a_bad_no_write, i_clk, i_rst_n, !empty && !o_recognized, !o_dest_written)
    `ASSERT_NXT(a_full_holds, i_clk, i_rst_n, full && !dec_pop, full)

endmodule

@@ sv/ase_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ase_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port (read returns old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ase_fifo.sv @@
// Small synchronous FIFO used between front, back and the result port.
module ase_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rp];

    // Advance pointers and count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ sv/ase_front.sv @@
// Instruction classifier: turns an opcode word into a decoded request.
module ase_front (
    input  logic [15:0]   i_word,
    output ase_pkg::t_dec o_dec
);

    // Opcode patterns of the supported subset
    localparam logic [7:0] PAT_ADD  = 8'h0C;
    localparam logic [7:0] PAT_ADC  = 8'h1C;
    localparam logic [7:0] PAT_SUB  = 8'h18;
    localparam logic [7:0] PAT_SBC  = 8'h08;
    localparam logic [7:0] PAT_CP   = 8'h14;
    localparam logic [7:0] PAT_MOV  = 8'h2C;
    localparam logic [7:0] PAT_SUBI = 8'h50;
    localparam logic [7:0] PAT_SBCI = 8'h40;
    localparam logic [7:0] PAT_CPI  = 8'h30;
    localparam logic [7:0] PAT_LDI  = 8'hE0;
    localparam logic [7:0] PAT_1OP  = 8'h94;
    localparam logic [7:0] PAT_SBI  = 8'h9A;
    localparam logic [7:0] PAT_RJMP = 8'hC0;
    localparam logic [3:0] LO_INC   = 4'h3;
    localparam logic [7:0] LO_BSET  = 8'h08;

    logic [7:0] hi, lo;
    logic [3:0] op;
    logic       upper_d;

    assign hi = i_word[15:8];
    assign lo = i_word[7:0];

    // Classify in priority order
    always_comb begin
        if ((hi & 8'hFC) == PAT_ADD) begin
            op = ase_pkg::OP_ADD;
        end else if ((hi & 8'hFC) == PAT_ADC) begin
            op = ase_pkg::OP_ADC;
        end else if ((hi & 8'hFC) == PAT_SUB) begin
            op = ase_pkg::OP_SUB;
        end else if ((hi & 8'hFC) == PAT_SBC) begin
            op = ase_pkg::OP_SBC;
        end else if ((hi & 8'hFC) == PAT_CP) begin
            op = ase_pkg::OP_CP;
        end else if ((hi & 8'hFC) == PAT_MOV) begin
            op = ase_pkg::OP_MOV;
        end else if ((hi & 8'hF0) == PAT_SUBI) begin
            op = ase_pkg::OP_SUBI;
        end else if ((hi & 8'hF0) == PAT_SBCI) begin
            op = ase_pkg::OP_SBCI;
        end else if ((hi & 8'hF0) == PAT_CPI) begin
            op = ase_pkg::OP_CPI;
        end else if ((hi & 8'hF0) == PAT_LDI) begin
            op = ase_pkg::OP_LDI;
        end else if ((hi & 8'hFE) == PAT_1OP && lo[3:0] == LO_INC) begin
            op = ase_pkg::OP_INC;
        end else if (hi == PAT_1OP && (lo & 8'h8F) == LO_BSET) begin
            op = ase_pkg::OP_BSET;
        end else if (hi == PAT_SBI) begin
            op = ase_pkg::OP_SBI;
        end else if ((hi & 8'hF0) == PAT_RJMP) begin
            op = ase_pkg::OP_RJMP;
        end else if (i_word == 16'h0000) begin
            op = ase_pkg::OP_NOP;
        end else begin
            op = ase_pkg::OP_BAD;
        end
    end

    // Immediate forms address only the upper sixteen registers
    assign upper_d = op inside {ase_pkg::OP_SUBI, ase_pkg::OP_SBCI,
                                ase_pkg::OP_CPI, ase_pkg::OP_LDI};

    // Extract operand fields
    always_comb begin
        o_dec.op   = op;
        o_dec.rd   = upper_d ? {1'b1, lo[7:4]} : {hi[0], lo[7:4]};
        o_dec.rr   = {hi[1], lo[3:0]};
        o_dec.kimm = {hi[3:0], lo[3:0]};
        o_dec.ioa  = lo[7:3];
        o_dec.bitn = (op == ase_pkg::OP_SBI) ? lo[2:0] : lo[6:4];
        o_dec.k12  = i_word[11:0];
    end

endmodule

@@ sv/ase_back.sv @@
// Execute unit: register file, I/O space, status register and program counter.
module ase_back #(
    parameter int PROGRAM_BYTES = ase_pkg::DEF_PROGRAM_BYTES,
    parameter int IO_BYTES      = ase_pkg::DEF_IO_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_dec_vld,
    input  ase_pkg::t_dec                    i_dec,
    output logic                             o_dec_pop,
    input  logic                             i_res_full,
    output logic                             o_res_push,
    output ase_pkg::t_res                    o_res,
    output logic [$clog2(PROGRAM_BYTES)-1:0] o_res_pc
);

    localparam int PC_W  = $clog2(PROGRAM_BYTES);
    localparam int SUM_W = (PC_W > 14) ? PC_W : 14;
    localparam int IO_AW = $clog2(IO_BYTES);
    localparam int RF_AW = $clog2(ase_pkg::REG_COUNT);

    // Architectural state
    logic [PC_W-1:0]               r_pc;
    logic [7:0]                    r_sreg;
    logic [ase_pkg::REG_COUNT-1:0] r_reg_vld;
    logic [IO_BYTES-1:0]           r_io_vld;

    // Execute stage
    logic          r_e_vld;
    ase_pkg::t_dec r_e_dec;
    logic          r_fa_hit, r_fb_hit, r_fi_hit;
    logic [7:0]    r_fa_val, r_fb_val, r_fi_val;
    logic          r_va, r_vb, r_vi;

    logic [7:0] ram_a, ram_b, ram_io;
    logic       e_fire, dec_pop;
    logic       wr_reg, wr_io, wr_io_mem;
    logic [7:0] opa, opr, opio, opb, val, n_sreg;
    logic       cin, chain, is_imm, recog;
    logic [7:0] add_res, sub_res, inc_res, cy, ov, bw, sov;
    logic       sub_z, inc_v;
    logic [6:0] idx;
    logic [PC_W-1:0]  npc, seq_pc;
    logic [13:0]      jdelta;
    logic [SUM_W-1:0] jsum;

    assign e_fire     = r_e_vld & ~i_res_full;
    assign dec_pop    = i_dec_vld & (~r_e_vld | e_fire);
    assign o_dec_pop  = dec_pop;
    assign o_res_push = e_fire;
    assign wr_io_mem  = wr_io & (r_e_dec.ioa != ase_pkg::SREG_IO);

    // Register file: two copies give two read ports
    ase_ram #(.WIDTH(8), .DEPTH(ase_pkg::REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (e_fire & wr_reg),
        .i_waddr (r_e_dec.rd),
        .i_wdata (val),
        .i_re    (dec_pop),
        .i_raddr (i_dec.rd),
        .o_rdata (ram_a)
    );

    ase_ram #(.WIDTH(8), .DEPTH(ase_pkg::REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (e_fire & wr_reg),
        .i_waddr (r_e_dec.rd),
        .i_wdata (val),
        .i_re    (dec_pop),
        .i_raddr (i_dec.rr),
        .o_rdata (ram_b)
    );

    // I/O space; the status byte lives in its own flop
    ase_ram #(.WIDTH(8), .DEPTH(IO_BYTES)) u_io (
        .i_clk   (i_clk),
        .i_we    (e_fire & wr_io_mem),
        .i_waddr (IO_AW'(r_e_dec.ioa)),
        .i_wdata (val),
        .i_re    (dec_pop),
        .i_raddr (IO_AW'(i_dec.ioa)),
        .o_rdata (ram_io)
    );

    // Select operands: forwarded value, stored value, or reset zero; the status byte comes from its flop
    always_comb begin
        opa = r_fa_hit ? r_fa_val : (r_va ? ram_a : 8'h00);
        opr = r_fb_hit ? r_fb_val : (r_vb ? ram_b : 8'h00);
        if (r_e_dec.ioa == ase_pkg::SREG_IO) begin
            opio = r_sreg;
        end else begin
            opio = r_fi_hit ? r_fi_val : (r_vi ? ram_io : 8'h00);
        end
    end

    // Adder, subtractor and incrementer with their flag terms
    always_comb begin
        is_imm  = r_e_dec.op inside {ase_pkg::OP_SUBI, ase_pkg::OP_SBCI, ase_pkg::OP_CPI};
        chain   = r_e_dec.op inside {ase_pkg::OP_SBC, ase_pkg::OP_SBCI};
        cin     = (r_e_dec.op inside {ase_pkg::OP_ADC, ase_pkg::OP_SBC, ase_pkg::OP_SBCI})
                  ? r_sreg[0] : 1'b0;
        opb     = is_imm ? r_e_dec.kimm : opr;
        add_res = opa + opb + {7'd0, cin};
        cy      = (opa & opb) | (opa & ~add_res) | (opb & ~add_res);
        ov      = (opa & opb & ~add_res) | (~opa & ~opb & add_res);
        sub_res = opa - opb - {7'd0, cin};
        bw      = (~opa & opb) | (opb & sub_res) | (sub_res & ~opa);
        sov     = (opa & ~opb & ~sub_res) | (~opa & opb & sub_res);
        sub_z   = (sub_res == 8'h00) & (~chain | r_sreg[1]);
        inc_res = opa + 8'd1;
        inc_v   = (inc_res == 8'h80);
    end

    // Sequential and jump targets, wrapping over program space
    always_comb begin
        seq_pc = r_pc + PC_W'(2);
        jdelta = {r_e_dec.k12[11], r_e_dec.k12, 1'b0} + 14'd2;
        jsum   = SUM_W'(r_pc) + SUM_W'($signed(jdelta));
    end

    // Carry out the operation
    always_comb begin
        n_sreg = r_sreg;
        val    = 8'h00;
        wr_reg = 1'b0;
        wr_io  = 1'b0;
        idx    = {2'b00, r_e_dec.rd};
        npc    = seq_pc;
        recog  = 1'b1;
        case (r_e_dec.op)
            ase_pkg::OP_ADD, ase_pkg::OP_ADC: begin
                val    = add_res;
                wr_reg = 1'b1;
                n_sreg = {r_sreg[7:6], cy[3], ov[7] ^ add_res[7], ov[7], add_res[7],
                          add_res == 8'h00, cy[7]};
            end
            ase_pkg::OP_SUB, ase_pkg::OP_SBC, ase_pkg::OP_SUBI, ase_pkg::OP_SBCI: begin
                val    = sub_res;
                wr_reg = 1'b1;
                n_sreg = {r_sreg[7:6], bw[3], sov[7] ^ sub_res[7], sov[7], sub_res[7],
                          sub_z, bw[7]};
            end
            ase_pkg::OP_CP, ase_pkg::OP_CPI: begin
                n_sreg = {r_sreg[7:6], bw[3], sov[7] ^ sub_res[7], sov[7], sub_res[7],
                          sub_z, bw[7]};
            end
            ase_pkg::OP_MOV: begin
                val    = opr;
                wr_reg = 1'b1;
            end
            ase_pkg::OP_LDI: begin
                val    = r_e_dec.kimm;
                wr_reg = 1'b1;
            end
            ase_pkg::OP_INC: begin
                val    = inc_res;
                wr_reg = 1'b1;
                n_sreg = {r_sreg[7:5], inc_v ^ inc_res[7], inc_v, inc_res[7],
                          inc_res == 8'h00, r_sreg[0]};
            end
            ase_pkg::OP_BSET: begin
                n_sreg = r_sreg | (8'h01 << r_e_dec.bitn);
            end
            ase_pkg::OP_SBI: begin
                val   = opio | (8'h01 << r_e_dec.bitn);
                wr_io = 1'b1;
                idx   = 7'h20 | {2'b00, r_e_dec.ioa};
                if (r_e_dec.ioa == ase_pkg::SREG_IO) begin
                    n_sreg = val;
                end
            end
            ase_pkg::OP_RJMP: begin
                npc = jsum[PC_W-1:0];
            end
            ase_pkg::OP_NOP: begin
                npc = seq_pc;
            end
            default: begin
                recog = 1'b0;
                npc   = r_pc;
            end
        endcase
    end

    // Result of the request in the execute stage
    always_comb begin
        o_res.recognized   = recog;
        o_res.status_byte  = n_sreg;
        o_res.dest_written = wr_reg | wr_io;
        o_res.dest_index   = (wr_reg | wr_io) ? idx : 7'd0;
        o_res.dest_value   = (wr_reg | wr_io) ? val : 8'h00;
        o_res_pc           = npc;
    end

    // Commit architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_sreg    <= 8'h00;
            r_reg_vld <= '0;
            r_io_vld  <= '0;
        end else if (e_fire) begin
            r_pc   <= npc;
            r_sreg <= n_sreg;
            if (wr_reg) begin
                r_reg_vld[r_e_dec.rd] <= 1'b1;
            end
            if (wr_io_mem) begin
                r_io_vld[IO_AW'(r_e_dec.ioa)] <= 1'b1;
            end
        end
    end

    // Advance the execute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (dec_pop) begin
            r_e_vld <= 1'b1;
        end else if (e_fire) begin
            r_e_vld <= 1'b0;
        end
    end

    // Load the next request; forward the write that lands on the same edge
    always_ff @(posedge i_clk) begin
        if (dec_pop) begin
            r_e_dec  <= i_dec;
            r_fa_hit <= e_fire & wr_reg & (r_e_dec.rd == i_dec.rd);
            r_fb_hit <= e_fire & wr_reg & (r_e_dec.rd == i_dec.rr);
            r_fi_hit <= e_fire & wr_io_mem & (r_e_dec.ioa == i_dec.ioa);
            r_fa_val <= val;
            r_fb_val <= val;
            r_fi_val <= val;
            r_va     <= r_reg_vld[RF_AW'(i_dec.rd)];
            r_vb     <= r_reg_vld[RF_AW'(i_dec.rr)];
            r_vi     <= r_io_vld[IO_AW'(i_dec.ioa)];
        end
    end

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the AVR subset execute block: directed and random instruction streams vs. predictor.
module tb_top;
    import ase_pkg::*;

    localparam int PC_BITS      = $clog2(DEF_PROGRAM_BYTES);
    localparam int RANDOM_ITEMS = 730;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no request or result moving
    localparam int END_WAIT     = 16;    // settling wait after every result is back

    // Status bits used by the flag logic
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;

    // Opcode prefixes of the supported subset
    localparam logic [5:0]  ENC_ADD     = 6'b000011;
    localparam logic [5:0]  ENC_ADC     = 6'b000111;
    localparam logic [5:0]  ENC_SUB     = 6'b000110;
    localparam logic [5:0]  ENC_SBC     = 6'b000010;
    localparam logic [5:0]  ENC_CP      = 6'b000101;
    localparam logic [5:0]  ENC_MOV     = 6'b001011;
    localparam logic [3:0]  ENC_SUBI    = 4'b0101;
    localparam logic [3:0]  ENC_SBCI    = 4'b0100;
    localparam logic [3:0]  ENC_CPI     = 4'b0011;
    localparam logic [3:0]  ENC_LDI     = 4'b1110;
    localparam logic [3:0]  ENC_RJMP    = 4'b1100;
    localparam logic [6:0]  ENC_INC     = 7'b1001010;
    localparam logic [3:0]  ENC_INC_LO  = 4'b0011;
    localparam logic [7:0]  ENC_BSET    = 8'h94;
    localparam logic [3:0]  ENC_BSET_LO = 4'b1000;
    localparam logic [7:0]  ENC_SBI     = 8'h9A;
    localparam logic [15:0] ENC_NOP     = 16'h0000;
    localparam logic [3:0]  ENC_NONE    = 4'hF;  // top nibble that decodes to nothing

    typedef struct packed {
        logic [PC_BITS-1:0] next_pc;
        logic               recognized;
        logic [7:0]         status;
        logic               written;
        logic [6:0]         index;
        logic [7:0]         value;
    } t_exec_result;

    typedef struct packed {
        logic        drain;  // hold the sender until every result is back
        logic [15:0] word;
        logic [3:0]  gap;    // idle cycles before this request
        logic        calm;   // no receiver stalls while this request is sent
    } t_feed_item;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic [15:0]        i_instruction = 16'h0000;
    logic               pop = 1'b0;
    logic               full;
    logic               empty;
    logic [PC_BITS-1:0] o_next_pc;
    logic               o_recognized;
    logic [7:0]         o_status_byte;
    logic               o_dest_written;
    logic [6:0]         o_dest_index;
    logic [7:0]         o_dest_value;

    // Predictor state
    logic [7:0]         gpr [REG_COUNT];
    logic [7:0]         io_mem [DEF_IO_BYTES];
    logic [PC_BITS-1:0] prog_pc;
    int unsigned        op_hits [16];

    t_feed_item   instr_feed [$];
    t_exec_result results_due [$];

    int unsigned idle_mode = 0;
    int unsigned requests_taken = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned drain_pauses = 0;
    int unsigned quiet_cycles = 0;
    int unsigned src_idle_left = 0;
    int unsigned sink_idle_left = 0;
    logic        gap_done = 1'b0;
    logic        sink_calm = 1'b1;
    logic        timed_out = 1'b0;

    avr_subset_execute dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_instruction  (i_instruction),
        .empty          (empty),
        .pop            (pop),
        .o_next_pc      (o_next_pc),
        .o_recognized   (o_recognized),
        .o_status_byte  (o_status_byte),
        .o_dest_written (o_dest_written),
        .o_dest_index   (o_dest_index),
        .o_dest_value   (o_dest_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Build one instruction word; d doubles as the I/O address, k as bit, immediate or offset
    function automatic logic [15:0] encode(logic [3:0] op, logic [4:0] d, logic [4:0] r,
                                           logic [11:0] k);
        case (op)
            OP_ADD:  return {ENC_ADD, r[4], d, r[3:0]};
            OP_ADC:  return {ENC_ADC, r[4], d, r[3:0]};
            OP_SUB:  return {ENC_SUB, r[4], d, r[3:0]};
            OP_SBC:  return {ENC_SBC, r[4], d, r[3:0]};
            OP_CP:   return {ENC_CP, r[4], d, r[3:0]};
            OP_MOV:  return {ENC_MOV, r[4], d, r[3:0]};
            OP_SUBI: return {ENC_SUBI, k[7:4], d[3:0], k[3:0]};
            OP_SBCI: return {ENC_SBCI, k[7:4], d[3:0], k[3:0]};
            OP_CPI:  return {ENC_CPI, k[7:4], d[3:0], k[3:0]};
            OP_LDI:  return {ENC_LDI, k[7:4], d[3:0], k[3:0]};
            OP_INC:  return {ENC_INC, d, ENC_INC_LO};
            OP_BSET: return {ENC_BSET, 1'b0, k[2:0], ENC_BSET_LO};
            OP_SBI:  return {ENC_SBI, d, k[2:0]};
            OP_RJMP: return {ENC_RJMP, k};
            OP_NOP:  return ENC_NOP;
            default: return {ENC_NONE, k};
        endcase
    endfunction

    function automatic logic [3:0] decode_word(logic [15:0] w);
        if (w[15:10] == ENC_ADD) return OP_ADD;
        if (w[15:10] == ENC_ADC) return OP_ADC;
        if (w[15:10] == ENC_SUB) return OP_SUB;
        if (w[15:10] == ENC_SBC) return OP_SBC;
        if (w[15:10] == ENC_CP) return OP_CP;
        if (w[15:10] == ENC_MOV) return OP_MOV;
        if (w[15:12] == ENC_SUBI) return OP_SUBI;
        if (w[15:12] == ENC_SBCI) return OP_SBCI;
        if (w[15:12] == ENC_CPI) return OP_CPI;
        if (w[15:12] == ENC_LDI) return OP_LDI;
        if (w[15:9] == ENC_INC && w[3:0] == ENC_INC_LO) return OP_INC;
        if (w[15:8] == ENC_BSET && !w[7] && w[3:0] == ENC_BSET_LO) return OP_BSET;
        if (w[15:8] == ENC_SBI) return OP_SBI;
        if (w[15:12] == ENC_RJMP) return OP_RJMP;
        if (w == ENC_NOP) return OP_NOP;
        return OP_BAD;
    endfunction

    // Refresh H S V N Z C, keep I and T
    function automatic void set_arith_flags(logic h, logic v, logic n, logic z, logic c);
        io_mem[SREG_IO] = {io_mem[SREG_IO][7:6], h, n ^ v, v, n, z, c};
    endfunction

    function automatic logic [7:0] add_bytes(logic [7:0] a, logic [7:0] b, logic cin);
        logic [7:0] s;
        logic [7:0] cy;
        s  = a + b + cin;
        cy = (a & b) | (a & ~s) | (b & ~s);
        set_arith_flags(cy[3], (a[7] & b[7] & ~s[7]) | (~a[7] & ~b[7] & s[7]), s[7],
                        s == 8'h00, cy[7]);
        return s;
    endfunction

    // Chained subtract only clears Z, never sets it
    function automatic logic [7:0] sub_bytes(logic [7:0] a, logic [7:0] b, logic cin,
                                             logic chain);
        logic [7:0] s;
        logic [7:0] bw;
        logic       z;
        s  = a - b - cin;
        bw = (~a & b) | (b & s) | (s & ~a);
        z  = (s == 8'h00) & (~chain | io_mem[SREG_IO][FLAG_Z]);
        set_arith_flags(bw[3], (a[7] & ~b[7] & ~s[7]) | (~a[7] & b[7] & s[7]), s[7], z,
                        bw[7]);
        return s;
    endfunction

    // Execute one word against the predictor state and return its result
    function automatic t_exec_result execute_word(logic [15:0] w);
        t_exec_result r;
        logic [3:0]   op;
        logic [4:0]   rd;
        logic [4:0]   rr;
        logic [4:0]   rdh;
        logic [4:0]   ioa;
        logic [7:0]   kimm;
        logic         cy;
        logic [7:0]   inc_val;
        op      = decode_word(w);
        rd      = w[8:4];
        rr      = {w[9], w[3:0]};
        rdh     = {1'b1, w[7:4]};
        ioa     = w[7:3];
        kimm    = {w[11:8], w[3:0]};
        cy      = io_mem[SREG_IO][FLAG_C];
        r       = '0;
        op_hits[op]++;
        r.recognized = (op != OP_BAD);
        r.next_pc    = (op == OP_BAD) ? prog_pc : prog_pc + PC_BITS'(2);
        r.written    = 1'b1;
        r.index      = {2'b00, rd};
        case (op)
            OP_ADD:  r.value = add_bytes(gpr[rd], gpr[rr], 1'b0);
            OP_ADC:  r.value = add_bytes(gpr[rd], gpr[rr], cy);
            OP_SUB:  r.value = sub_bytes(gpr[rd], gpr[rr], 1'b0, 1'b0);
            OP_SBC:  r.value = sub_bytes(gpr[rd], gpr[rr], cy, 1'b1);
            OP_MOV:  r.value = gpr[rr];
            OP_SUBI: begin
                r.value = sub_bytes(gpr[rdh], kimm, 1'b0, 1'b0);
                r.index = {2'b00, rdh};
            end
            OP_SBCI: begin
                r.value = sub_bytes(gpr[rdh], kimm, cy, 1'b1);
                r.index = {2'b00, rdh};
            end
            OP_LDI: begin
                r.value = kimm;
                r.index = {2'b00, rdh};
            end
            OP_INC: begin
                inc_val = gpr[rd] + 8'h01;
                io_mem[SREG_IO] = {io_mem[SREG_IO][7:5], inc_val[7] ^ (inc_val == 8'h80),
                                   inc_val == 8'h80, inc_val[7], inc_val == 8'h00,
                                   io_mem[SREG_IO][FLAG_C]};
                r.value = inc_val;
            end
            OP_SBI: begin
                r.value = io_mem[ioa] | (8'h01 << w[2:0]);
                r.index = 7'(REG_COUNT) + 7'(ioa);
            end
            default: begin
                // compare, flag set, jump, nop and unknown words write nothing
                r.written = 1'b0;
                r.index   = '0;
                case (op)
                    OP_CP:   void'(sub_bytes(gpr[rd], gpr[rr], 1'b0, 1'b0));
                    OP_CPI:  void'(sub_bytes(gpr[rdh], kimm, 1'b0, 1'b0));
                    OP_BSET: io_mem[SREG_IO][w[6:4]] = 1'b1;
                    OP_RJMP: r.next_pc = prog_pc + PC_BITS'(2) + {w[PC_BITS-2:0], 1'b0};
                    default: ;
                endcase
            end
        endcase
        if (r.written) begin
            if (op == OP_SBI) io_mem[ioa] = r.value;
            else gpr[r.index[4:0]] = r.value;
        end
        prog_pc  = r.next_pc;
        r.status = io_mem[SREG_IO];
        return r;
    endfunction

    function automatic logic [4:0] pick_reg();
        // favor a small pool so back-to-back dependencies are common
        if ($urandom_range(0, 1) == 0) return 5'($urandom_range(16, 19));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [7:0] pick_imm();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed instructions with random operands, some raw noise
    function automatic logic [15:0] random_word();
        logic [3:0] op;
        if ($urandom_range(0, 99) < 12) return 16'($urandom);
        op = 4'($urandom_range(OP_NOP, OP_RJMP));
        if ($urandom_range(0, 9) == 0) op = OP_LDI;
        return encode(op, pick_reg(), pick_reg(), {4'($urandom), pick_imm()});
    endfunction

    task automatic plan_word(logic [15:0] w);
        t_feed_item it;
        it       = '0;
        it.word  = w;
        it.calm  = (idle_mode == 0);
        if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 9 : 2) == 0)
            it.gap = 4'($urandom_range(1, 12));
        instr_feed.push_back(it);
    endtask

    task automatic plan_drain();
        t_feed_item it;
        it       = '0;
        it.drain = 1'b1;
        it.calm  = 1'b1;
        instr_feed.push_back(it);
    endtask

    task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    // Drive requests from the feed queue, predict each one as it is taken
    always @(posedge i_clk) begin : drive_requests
        logic        push_next;
        logic [15:0] word_next;
        t_feed_item  head;
        push_next = push;
        word_next = i_instruction;
        if (!i_rst_n) begin
            push_next = 1'b0;
        end else begin
            if (push && !full) begin
                results_due.push_back(execute_word(i_instruction));
                requests_taken++;
                push_next = 1'b0;
            end
            if (!push_next) begin
                if (src_idle_left > 0) begin
                    src_idle_left--;
                end else if (instr_feed.size() > 0) begin
                    head = instr_feed[0];
                    if (head.drain) begin
                        if (results_due.size() == 0) begin
                            drain_pauses++;
                            void'(instr_feed.pop_front());
                        end
                    end else if (head.gap != 0 && !gap_done) begin
                        src_idle_left = head.gap - 1;
                        gap_done = 1'b1;
                    end else begin
                        void'(instr_feed.pop_front());
                        gap_done  = 1'b0;
                        push_next = 1'b1;
                        word_next = head.word;
                        sink_calm <= head.calm;
                    end
                end
            end
        end
        push <= push_next;
        i_instruction <= word_next;
    end

    // Take results, compare with the oldest prediction, stall in bursts
    always @(posedge i_clk) begin : take_results
        t_exec_result want;
        logic         pop_next;
        pop_next = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                results_checked++;
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing pending, next_pc 0x%0h",
                             $time, o_next_pc);
                end else begin
                    want = results_due.pop_front();
                    compare_field("next_pc", want.next_pc, o_next_pc);
                    compare_field("recognized", want.recognized, o_recognized);
                    compare_field("status_byte", want.status, o_status_byte);
                    compare_field("dest_written", want.written, o_dest_written);
                    compare_field("dest_index", want.index, o_dest_index);
                    compare_field("dest_value", want.value, o_dest_value);
                end
            end
            if (sink_idle_left > 0) begin
                sink_idle_left--;
            end else if (!sink_calm && $urandom_range(0, 7) == 0) begin
                sink_idle_left = $urandom_range(0, 11);
            end else begin
                pop_next = 1'b1;
            end
        end
        pop <= pop_next;
    end

    // Flag a hang when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) timed_out <= 1'b1;
    end

    initial begin : run_test
        int unsigned classes_hit;
        foreach (gpr[i]) gpr[i] = 8'h00;
        foreach (io_mem[i]) io_mem[i] = 8'h00;
        foreach (op_hits[i]) op_hits[i] = 0;
        prog_pc = '0;

        // Directed: operand extremes, every class, flag corner cases
        idle_mode = $urandom_range(0, 2);
        plan_word(encode(OP_NOP, 5'd0, 5'd0, 12'h000));
        plan_word(encode(OP_LDI, 5'd16, 5'd0, 12'h0FF));
        plan_word(encode(OP_LDI, 5'd31, 5'd0, 12'h080));
        plan_word(encode(OP_LDI, 5'd17, 5'd0, 12'h07F));
        plan_word(encode(OP_MOV, 5'd0, 5'd16, 12'h000));
        plan_word(encode(OP_ADD, 5'd0, 5'd31, 12'h000));    // carry and overflow
        plan_word(encode(OP_ADC, 5'd0, 5'd0, 12'h000));
        plan_word(encode(OP_INC, 5'd17, 5'd0, 12'h000));    // 0x7F -> 0x80 overflow
        plan_word(encode(OP_INC, 5'd16, 5'd0, 12'h000));    // wrap to zero
        plan_word(encode(OP_CP, 5'd16, 5'd16, 12'h000));    // set Z, no destination
        plan_word(encode(OP_SBC, 5'd16, 5'd16, 12'h000));   // zero result keeps Z set
        plan_word(encode(OP_SBCI, 5'd16, 5'd0, 12'h001));   // borrow, Z cleared
        plan_word(encode(OP_SBCI, 5'd16, 5'd0, 12'h0FE));   // zero result keeps Z clear
        plan_word(encode(OP_SUB, 5'd31, 5'd17, 12'h000));
        plan_word(encode(OP_SUBI, 5'd17, 5'd0, 12'h001));   // 0x80 - 1 overflow
        plan_word(encode(OP_CPI, 5'd31, 5'd0, 12'h0FF));
        plan_word(encode(OP_BSET, 5'd0, 5'd0, 12'h000));
        plan_word(encode(OP_BSET, 5'd0, 5'd0, 12'h007));
        plan_word(encode(OP_SBI, SREG_IO, 5'd0, 12'h006));  // set a bit in the status byte
        plan_word(encode(OP_SBI, 5'd0, 5'd0, 12'h007));
        plan_word(encode(OP_RJMP, 5'd0, 5'd0, 12'hFFF));    // jump to itself
        plan_word(encode(OP_RJMP, 5'd0, 5'd0, 12'h7FF));
        plan_word(encode(OP_RJMP, 5'd0, 5'd0, 12'h800));    // backward, wraps below zero
        plan_word(encode(OP_BAD, 5'd0, 5'd0, 12'hFFF));     // unknown word
        plan_drain();

        // Random stream, idling off in the tail
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) idle_mode = (n >= RANDOM_ITEMS - 100) ? 0 : $urandom_range(0, 2);
            if (n == RANDOM_ITEMS / 2) plan_drain();
            plan_word(random_word());
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out && !(instr_feed.size() == 0 && !push && results_due.size() == 0))
            @(negedge i_clk);
        if (!timed_out) repeat (END_WAIT) @(negedge i_clk);

        classes_hit = 0;
        foreach (op_hits[i]) if (op_hits[i] != 0) classes_hit++;
        $display("Executed %0d instructions across %0d of 16 decode classes, %0d results checked.",
                 requests_taken, classes_hit, results_checked);
        $display("Drain pauses %0d, mismatches %0d, results still owed %0d, hang %0d.",
                 drain_pauses, mismatches, results_due.size(), timed_out);
        if (!timed_out && mismatches == 0 && results_due.size() == 0) begin
            $display("avr_subset_execute test passed");
        end else begin
            $display("avr_subset_execute test failed");
        end
        $finish;
    end
endmodule
